[hw/rtl/iirdf1_pkg.sv]
// Shared constants, types and coefficient tables for the direct form I IIR filter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package iirdf1_pkg;

	// Filter order and history geometry.
	localparam int TAPS     = 9;
	localparam int HIST_LEN = TAPS - 1;
	localparam int ADDR_W   = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
	localparam int FILL_W   = $clog2(HIST_LEN + 1);
	localparam int STEP_W   = $clog2(2 * HIST_LEN + 1);

	// Coefficient ROM size and index width.
	localparam int ROM_LEN = 32;
	localparam int TAP_W   = $clog2(ROM_LEN);

	// Datapath widths.
	localparam int SAMPLE_W = 16;   // Q1.15 samples
	localparam int HIST_W   = 24;   // Q1.23 output history
	localparam int X_ALIGN  = HIST_W - SAMPLE_W;
	localparam int COEF_W   = 24;   // Q4.20 coefficients
	localparam int OPND_W   = 24;
	localparam int PROD_W   = COEF_W + OPND_W;
	localparam int ACC_W    = 52;   // 43 fraction bits plus headroom for 17 terms
	localparam int HIST_SH  = 20;   // accumulator to Q1.23
	localparam int OUT_SH   = 28;   // accumulator to Q1.15

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic signed [HIST_W-1:0]   y;
	} row_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		row_t              wr_row;
	} mem_req_t;

	typedef struct packed {
		logic op_valid;
		logic op_neg;
		logic acc_clear;
	} mac_ctl_t;

	typedef struct packed {
		logic                       busy;
		logic signed [SAMPLE_W-1:0] y16;
		logic signed [HIST_W-1:0]   y24;
	} mac_res_t;

	// Feed-forward coefficients a[i], Q4.20, zero past the table.
	function automatic logic signed [COEF_W-1:0] coef_fwd(input logic [TAP_W-1:0] idx);
		logic signed [COEF_W-1:0] c;
		case (idx)
			TAP_W'(0): c = 24'sd141117;
			TAP_W'(2): c = -24'sd564448;
			TAP_W'(4): c = 24'sd846683;
			TAP_W'(6): c = -24'sd564448;
			TAP_W'(8): c = 24'sd141117;
			default:   c = '0;
		endcase
		return c;
	endfunction

	// Feedback coefficients b[i], Q4.20, zero past the table.
	function automatic logic signed [COEF_W-1:0] coef_fb(input logic [TAP_W-1:0] idx);
		logic signed [COEF_W-1:0] c;
		case (idx)
			TAP_W'(0): c = 24'sd1048576;
			TAP_W'(1): c = -24'sd2592689;
			TAP_W'(2): c = 24'sd2236316;
			TAP_W'(3): c = -24'sd1345630;
			TAP_W'(4): c = 24'sd1482480;
			TAP_W'(5): c = -24'sd1070612;
			TAP_W'(6): c = 24'sd275694;
			TAP_W'(7): c = -24'sd59843;
			TAP_W'(8): c = 24'sd36759;
			default:   c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/iirdf1_if.sv]
// Valid/ready stream interfaces for the filter's sample channels.
// Depends on iirdf1_pkg for the sample width.
`default_nettype none

interface iirdf1_in_if;
	import iirdf1_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface iirdf1_out_if;
	import iirdf1_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

[hw/rtl/iirdf1_hist_mem.sv]
// History memory: one row per past sample, holding x[n-k] and y[n-k] side by side.
// One write and one registered read per cycle. Depends on iirdf1_pkg.
`default_nettype none

module iirdf1_hist_mem (
	input  wire                 clk,
	input  iirdf1_pkg::mem_req_t req,
	output iirdf1_pkg::row_t     rd_row
);
	import iirdf1_pkg::*;

	row_t mem_q [HIST_LEN];
	row_t rd_row_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_row;
		end
		if (req.rd_en) begin
			rd_row_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_row = rd_row_q;

endmodule

`default_nettype wire

[hw/rtl/iirdf1_mac.sv]
// Shared multiply-accumulate unit with round and saturate of the accumulator.
// Operand register, product register, accumulator. Depends on iirdf1_pkg.
`default_nettype none

module iirdf1_mac (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  iirdf1_pkg::mac_ctl_t                   ctl,
	input  wire signed [iirdf1_pkg::COEF_W-1:0]    coef,
	input  wire signed [iirdf1_pkg::OPND_W-1:0]    opnd,
	output iirdf1_pkg::mac_res_t                   res
);
	import iirdf1_pkg::*;

	logic signed [COEF_W-1:0] coef_s1;
	logic signed [OPND_W-1:0] opnd_s1;
	logic                     neg_s1;
	logic                     valid_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     neg_s2;
	logic                     valid_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  r24;
	logic signed [ACC_W-1:0]  r16;
	logic                     fit24;
	logic                     fit16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.op_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		coef_s1 <= coef;
		opnd_s1 <= opnd;
		neg_s1  <= ctl.op_neg;
		prod_s2 <= coef_s1 * opnd_s1;
		neg_s2  <= neg_s1;
		if (ctl.acc_clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= neg_s2 ? (acc_q - prod_ext) : (acc_q + prod_ext);
		end
	end

	always_comb begin
		prod_ext = ACC_W'(prod_s2);
		r24 = acc_q + ACC_W'(64'd1 << (HIST_SH - 1));
		r16 = acc_q + ACC_W'(64'd1 << (OUT_SH - 1));
		// The rounded value fits when every bit above its sign bit agrees with it.
		fit24 = (&r24[ACC_W-1:HIST_SH+HIST_W-1]) | ~(|r24[ACC_W-1:HIST_SH+HIST_W-1]);
		fit16 = (&r16[ACC_W-1:OUT_SH+SAMPLE_W-1]) | ~(|r16[ACC_W-1:OUT_SH+SAMPLE_W-1]);
		res.busy = valid_s1 | valid_s2;
		res.y24 = fit24 ? r24[HIST_SH+HIST_W-1:HIST_SH]
			: {r24[ACC_W-1], {(HIST_W-1){~r24[ACC_W-1]}}};
		res.y16 = fit16 ? r16[OUT_SH+SAMPLE_W-1:OUT_SH]
			: {r16[ACC_W-1], {(SAMPLE_W-1){~r16[ACC_W-1]}}};
	end

endmodule

`default_nettype wire

[hw/rtl/iirdf1_seq.sv]
// Sequencer: stream handshakes, history addressing, tap stepping and write-back.
// Drives iirdf1_hist_mem and iirdf1_mac. Depends on iirdf1_pkg and iirdf1_if.
`default_nettype none

module iirdf1_seq (
	input  wire                                 clk,
	input  wire                                 arst_n,
	iirdf1_in_if.sink                           x_chan,
	iirdf1_out_if.source                        y_chan,
	output iirdf1_pkg::mem_req_t                mem_req,
	input  iirdf1_pkg::row_t                    rd_row,
	output iirdf1_pkg::mac_ctl_t                mac_ctl,
	output logic signed [iirdf1_pkg::COEF_W-1:0] coef,
	output logic signed [iirdf1_pkg::OPND_W-1:0] opnd,
	input  iirdf1_pkg::mac_res_t                mac_res
);
	import iirdf1_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_MAC    = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t                     state_q;
	logic [STEP_W-1:0]          step_q;
	logic [ADDR_W-1:0]          wptr_q;
	logic [ADDR_W-1:0]          rd_addr_q;
	logic [FILL_W-1:0]          fill_q;
	logic                       ok_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] out_q;
	logic                       out_valid_q;

	logic                       accept;
	logic                       rd_issue;
	logic                       last_step;
	logic                       done;
	logic                       is_fb;
	logic [TAP_W:0]             tap_sum;
	logic [TAP_W-1:0]           tap;
	logic [STEP_W-1:0]          age;

	function automatic logic [ADDR_W-1:0] addr_prev(input logic [ADDR_W-1:0] a);
		return (a == '0) ? ADDR_W'(HIST_LEN - 1) : a - ADDR_W'(1);
	endfunction

	always_comb begin
		accept    = x_chan.valid && x_chan.ready;
		last_step = (step_q == STEP_W'(2 * HIST_LEN));
		rd_issue  = (state_q == S_MAC) && !step_q[0] && (step_q < STEP_W'(2 * HIST_LEN));
		done      = (state_q == S_FINISH) && !mac_res.busy && (!out_valid_q || y_chan.ready);
		// Step 0 is a[0]*x[n]; odd steps are a[i]*x[n-i]; even steps are b[i]*y[n-i].
		is_fb     = !step_q[0] && (step_q != '0);
		tap_sum   = (TAP_W + 1)'(step_q) + (TAP_W + 1)'(1);
		tap       = tap_sum[TAP_W:1];
		age       = (step_q >> 1) + STEP_W'(1);

		coef = is_fb ? coef_fb(tap) : coef_fwd(tap);
		if (step_q == '0) begin
			opnd = {x_q, {X_ALIGN{1'b0}}};
		end else if (!ok_q) begin
			opnd = '0;
		end else if (is_fb) begin
			opnd = rd_row.y;
		end else begin
			opnd = {rd_row.x, {X_ALIGN{1'b0}}};
		end

		mac_ctl.op_valid  = (state_q == S_MAC);
		mac_ctl.op_neg    = is_fb;
		mac_ctl.acc_clear = accept;

		mem_req.rd_en    = rd_issue;
		mem_req.rd_addr  = rd_addr_q;
		mem_req.wr_en    = done;
		mem_req.wr_addr  = wptr_q;
		mem_req.wr_row.x = x_q;
		mem_req.wr_row.y = mac_res.y24;
	end

	assign x_chan.ready      = (state_q == S_IDLE);
	assign y_chan.valid      = out_valid_q;
	assign y_chan.sample_out = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			wptr_q      <= '0;
			rd_addr_q   <= '0;
			fill_q      <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (y_chan.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q    <= '0;
						rd_addr_q <= addr_prev(wptr_q);
						state_q   <= S_MAC;
					end
				end
				S_MAC: begin
					if (rd_issue) begin
						rd_addr_q <= addr_prev(rd_addr_q);
						ok_q      <= (age <= STEP_W'(fill_q));
					end
					if (last_step) begin
						state_q <= S_FINISH;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_FINISH: begin
					if (done) begin
						wptr_q  <= (wptr_q == ADDR_W'(HIST_LEN - 1)) ? '0
							: wptr_q + ADDR_W'(1);
						if (fill_q != FILL_W'(HIST_LEN)) begin
							fill_q <= fill_q + FILL_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= x_chan.sample_in;
		end
		if (done) begin
			out_q <= mac_res.y16;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/iir_filter_direct_form_one.sv]
// Top level of the eighth-order direct form I IIR filter.
// Instantiates iirdf1_seq, iirdf1_hist_mem and iirdf1_mac; uses iirdf1_pkg and iirdf1_if.
`default_nettype none

// This block filters a stream of signed 16-bit Q1.15 samples with a fixed eighth-order
// direct form I IIR filter whose coefficients live in a ROM as signed Q4.20. For each
// sample it computes a[0]*x[n] plus the sum of a[i]*x[n-i] minus the sum of b[i]*y[n-i]
// for i from 1 to TAPS-1, exactly, in a 52-bit accumulator with 43 fraction bits, then
// rounds half up and saturates to a 16-bit output sample and to a 24-bit Q1.23 value
// that goes back into the output history. Both histories share one memory row per past
// sample, kept as a circular buffer; after reset the rows not yet written read as zero
// through a fill count, so no clearing pass is needed. One sample is in flight at a time:
// the input beat is taken only while the filter is idle, and the next sample can be taken
// once the single shared 24x24 multiplier has performed 2*(TAPS-1)+1 products, one per
// cycle, the products have passed its two pipeline stages, and the sum has been rounded
// and written back. The memory is read once per history row, so its read port is never
// the limit. The result sits in an output register; a new sample may be accepted while
// that beat still waits, and the filter holds its next result until the output register
// is free.
module iir_filter_direct_form_one (
	input  wire          clk,
	input  wire          arst_n,
	iirdf1_in_if.sink    x_chan,
	iirdf1_out_if.source y_chan
);
	import iirdf1_pkg::*;

	mem_req_t                 mem_req;
	row_t                     rd_row;
	mac_ctl_t                 mac_ctl;
	mac_res_t                 mac_res;
	logic signed [COEF_W-1:0] coef;
	logic signed [OPND_W-1:0] opnd;

	// Sequencer owns both handshakes and walks the taps.
	iirdf1_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.x_chan  (x_chan),
		.y_chan  (y_chan),
		.mem_req (mem_req),
		.rd_row  (rd_row),
		.mac_ctl (mac_ctl),
		.coef    (coef),
		.opnd    (opnd),
		.mac_res (mac_res)
	);

	// Past inputs and outputs, one row per sample age.
	iirdf1_hist_mem u_mem (
		.clk    (clk),
		.req    (mem_req),
		.rd_row (rd_row)
	);

	// Shared multiplier and accumulator, with the rounding of the final sum.
	iirdf1_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (coef),
		.opnd   (opnd),
		.res    (mac_res)
	);

endmodule

`default_nettype wire

[hw/rtl/iirdf1_checker.sv]
// Port-level checks for the IIR filter, bound to iir_filter_direct_form_one.
// Depends on iirdf1_pkg for the sample width.
`default_nettype none

module iirdf1_checker (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  in_valid,
	input wire                                  in_ready,
	input wire                                  out_valid,
	input wire                                  out_ready,
	input wire signed [iirdf1_pkg::SAMPLE_W-1:0] sample_out
);
	import iirdf1_pkg::*;

	// A result beat stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped before it was taken");

	// A stalled result beat keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample_out))
		else $error("output sample changed while stalled");

	// Only one sample is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a beat");

	// A result cannot appear in the cycle after its sample was taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind iir_filter_direct_form_one iirdf1_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (x_chan.valid),
	.in_ready   (x_chan.ready),
	.out_valid  (y_chan.valid),
	.out_ready  (y_chan.ready),
	.sample_out (y_chan.sample_out)
);

`default_nettype wire

[test/iir_filter_direct_form_one_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for iir_filter_direct_form_one: streams Q1.15 samples through the
// filter and compares every output beat against a bit-exact software copy of the recursion.
// Depends on iirdf1_pkg, the iirdf1 stream interfaces and the filter RTL.

module iir_filter_direct_form_one_test;
	import iirdf1_pkg::*;

	// Bench timing and run length.
	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 10;
	localparam int MAX_IDLE      = 17;
	localparam int STALL_LIMIT   = 2000;
	localparam int LONG_HOLD     = 400;
	localparam int TOTAL_SAMPLES = 1450;
	localparam int SETTLE_CYCLES = 2 * HIST_LEN + 20;
	localparam int MAX_PRINTED   = 100;

	// Fixed-point layout of the accumulator: 43 fraction bits. The history keeps 23 of
	// them and the output sample 15, so the shifts below drop 20 and 28 bits.
	localparam int NUM_COEF   = 9;
	localparam int HIST_SHIFT = 20;
	localparam int OUT_SHIFT  = 28;
	localparam longint HIST_MAX = (longint'(1) << (HIST_W - 1)) - 1;
	localparam longint HIST_MIN = -(longint'(1) << (HIST_W - 1));
	localparam longint OUT_MAX  = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint OUT_MIN  = -(longint'(1) << (SAMPLE_W - 1));

	// Shapes of the random bursts. Most of them sit on the filter's passband at a quarter
	// of the sample rate, where the resonance builds up and drives the clamps.
	typedef enum int {
		BURST_QUARTER_SQUARE,
		BURST_QUARTER_SINE,
		BURST_NOISE,
		BURST_QUIET_NOISE,
		BURST_SILENCE
	} burst_kind_e;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	iirdf1_in_if  x_chan ();
	iirdf1_out_if y_chan ();

	iir_filter_direct_form_one uut (
		.clk    (clk),
		.arst_n (arst_n),
		.x_chan (x_chan),
		.y_chan (y_chan)
	);

	always #HALF_PERIOD clk = ~clk;

	// Coefficients in Q4.20, each the design value rounded to nearest. The feedback table
	// starts with b[0] = 1.0, which the recursion never multiplies.
	longint fwd_q420 [NUM_COEF] = '{141117, 0, -564448, 0, 846683, 0, -564448, 0, 141117};
	longint fb_q420 [NUM_COEF]  = '{1048576, -2592689, 2236316, -1345630, 1482480,
		-1070612, 275694, -59843, 36759};

	// The predictor's own copy of the filter state: past inputs at sample width and past
	// outputs at the wider Q1.23 history width, newest first.
	logic signed [SAMPLE_W-1:0] past_x [HIST_LEN];
	logic signed [HIST_W-1:0]   past_y [HIST_LEN];

	// Filtered samples that are owed by the block, oldest first.
	logic signed [SAMPLE_W-1:0] pending_outputs [$];

	// Knobs shared between the stimulus and the output side.
	bit send_gaps    = 1'b1;
	bit take_gaps    = 1'b1;
	int hold_request = 0;

	// Bookkeeping for the summary.
	int errors          = 0;
	int samples_sent    = 0;
	int outputs_seen    = 0;
	int clipped_outputs = 0;
	int clipped_history = 0;
	int quiet_cycles    = 0;

	// Advances the predicted filter by one sample and returns the output sample. The sum
	// is exact in 64 bits: each product stays below 2^45 and there are only 17 of them.
	function automatic logic signed [SAMPLE_W-1:0] filter_sample(
		input logic signed [SAMPLE_W-1:0] x
	);
		longint acc;
		longint y_hist;
		longint y_out;
		int     i;
		// Input terms carry 35 fraction bits, so they are lifted by 2^8 to line up
		// with the feedback terms, which already carry 43.
		acc = fwd_q420[0] * longint'(x) * 256;
		for (i = 1; i < TAPS; i++) begin
			if (i < NUM_COEF) begin
				acc += fwd_q420[i] * longint'(past_x[i-1]) * 256;
				acc -= fb_q420[i] * longint'(past_y[i-1]);
			end
		end
		// Round half up: add half an LSB and floor with an arithmetic shift.
		y_hist = (acc + (longint'(1) << (HIST_SHIFT - 1))) >>> HIST_SHIFT;
		y_out  = (acc + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
		if (y_hist > HIST_MAX || y_hist < HIST_MIN) begin
			clipped_history++;
			y_hist = (y_hist > HIST_MAX) ? HIST_MAX : HIST_MIN;
		end
		if (y_out > OUT_MAX || y_out < OUT_MIN) begin
			clipped_outputs++;
			y_out = (y_out > OUT_MAX) ? OUT_MAX : OUT_MIN;
		end
		for (i = HIST_LEN - 1; i > 0; i--) begin
			past_x[i] = past_x[i-1];
			past_y[i] = past_y[i-1];
		end
		past_x[0] = x;
		past_y[0] = HIST_W'(y_hist);
		return SAMPLE_W'(y_out);
	endfunction

	// Every mismatch goes through here. The printout is capped so that a badly broken
	// block cannot flood the log, but every mismatch is still counted.
	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// Offers one sample and returns at the edge where the beat is taken. Valid is left
	// high on return; the next call lowers it only if it draws a gap, so valid never gets
	// two assignments in one time step. The prediction is made at acceptance, in order.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
		int gap;
		gap = send_gaps ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			x_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		x_chan.valid     <= 1'b1;
		x_chan.sample_in <= value;
		@(posedge clk);
		while (!x_chan.ready) @(posedge clk);
		pending_outputs.push_back(filter_sample(value));
		samples_sent++;
	endtask

	// Full-scale and bit-pattern extremes. The leading positive full-scale sample after
	// the silent reset state also acts as an impulse for the samples that follow.
	task automatic test_extremes();
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(-16'sh0001);
		send_sample(16'sh0001);
		send_sample(16'sh5555);
		send_sample(16'shAAAA);
	endtask

	// A full-scale square wave at a quarter of the sample rate lands in the passband with
	// a fundamental about 1.4 times full scale, which pushes both the output sample and
	// the stored history into saturation.
	task automatic test_clipping();
		int n;
		for (n = 0; n < 16; n++)
			send_sample(((n & 2) == 0) ? 16'sh7FFF : 16'sh8000);
	endtask

	// The output side is told to hold ready low for a long stretch while samples keep
	// coming with no gaps. The result register and the filter both fill, after which the
	// block has to refuse the input beat until the hold ends.
	task automatic test_backpressure();
		int n;
		hold_request = LONG_HOLD;
		send_gaps    = 1'b0;
		for (n = 0; n < 30; n++)
			send_sample(16'($urandom()));
		send_gaps = 1'b1;
	endtask

	// Random bursts until the run has sent its share of samples. Each burst picks a shape,
	// an amplitude, a phase and whether either side idles, so stretches with no gaps at
	// all alternate with stretches where both sides dawdle.
	task automatic test_random_stream();
		int                         draw;
		int                         len;
		int                         phase;
		int                         n;
		burst_kind_e                kind;
		logic signed [SAMPLE_W-1:0] amp;
		logic signed [SAMPLE_W-1:0] value;
		while (samples_sent < TOTAL_SAMPLES) begin
			draw = $urandom_range(0, 9);
			if (draw < 5)
				kind = BURST_QUARTER_SQUARE;
			else if (draw < 6)
				kind = BURST_QUARTER_SINE;
			else if (draw < 8)
				kind = BURST_NOISE;
			else if (draw < 9)
				kind = BURST_QUIET_NOISE;
			else
				kind = BURST_SILENCE;
			len   = $urandom_range(8, 64);
			phase = $urandom_range(0, 3);
			amp   = ($urandom_range(0, 3) == 0) ? 16'sh7FFF : 16'($urandom_range(0, 32767));
			send_gaps = ($urandom_range(0, 3) != 0);
			take_gaps = ($urandom_range(0, 3) != 0);
			for (n = 0; n < len; n++) begin
				case (kind)
					BURST_QUARTER_SQUARE: begin
						// The bitwise inverse of a positive amplitude reaches -32768.
						value = (((n + phase) & 2) == 0) ? amp : ~amp;
					end
					BURST_QUARTER_SINE: begin
						if (((n + phase) & 1) == 1)
							value = '0;
						else
							value = (((n + phase) & 2) == 0) ? amp : ~amp;
					end
					BURST_NOISE: begin
						value = 16'($urandom());
					end
					BURST_QUIET_NOISE: begin
						value = 16'($urandom_range(0, 511));
						value = value - 16'sd256;
					end
					default: begin
						value = '0;
					end
				endcase
				send_sample(value);
			end
		end
		send_gaps = 1'b1;
		take_gaps = 1'b1;
	endtask

	// Stimulus: reset once, run the tests in turn, then drain and give the verdict.
	initial begin : stimulus
		int i;
		int waited;
		for (i = 0; i < HIST_LEN; i++) begin
			past_x[i] = '0;
			past_y[i] = '0;
		end
		x_chan.valid     <= 1'b0;
		x_chan.sample_in <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_clipping();
		test_backpressure();
		test_random_stream();

		// The last beat was taken in this time step, so valid is lowered only once here.
		x_chan.valid <= 1'b0;
		waited = 0;
		while (pending_outputs.size() != 0 && waited < STALL_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		// Keep running for SETTLE_CYCLES more so that any stray extra beat is caught.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_outputs.size() != 0)
			report_mismatch($sformatf("%0d filtered samples never came out",
				pending_outputs.size()));

		$display("Run covered %0d input beats and %0d output beats, with %0d mismatches.",
			samples_sent, outputs_seen, errors);
		$display("Saturation was hit by %0d output samples and %0d history words.",
			clipped_outputs, clipped_history);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Output side: stalls for a drawn number of cycles (or the long hold when one is
	// asked for), then raises ready and compares the next beat with the oldest pending
	// sample. Like valid on the input, ready stays high into the next beat when no stall
	// is drawn.
	initial begin : output_side
		int                         stall;
		logic signed [SAMPLE_W-1:0] want;
		y_chan.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request > 0) begin
				stall        = hold_request;
				hold_request = 0;
			end else begin
				stall = take_gaps ? $urandom_range(0, MAX_IDLE) : 0;
			end
			if (stall > 0) begin
				y_chan.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			y_chan.ready <= 1'b1;
			@(posedge clk);
			while (!y_chan.valid) @(posedge clk);
			if (pending_outputs.size() == 0) begin
				report_mismatch($sformatf("output beat %0d (%0d) with no sample pending",
					outputs_seen, y_chan.sample_out));
			end else begin
				want = pending_outputs.pop_front();
				if (y_chan.sample_out !== want)
					report_mismatch($sformatf("output beat %0d: sample_out %0d, expected %0d",
						outputs_seen, y_chan.sample_out, want));
			end
			outputs_seen++;
		end
	end

	// Watchdog: a hung handshake shows up as a long run of cycles with no beat on either
	// channel. The limit is several times the longest legitimate quiet stretch, which is
	// the long output hold.
	always @(posedge clk) begin
		if (!arst_n || (x_chan.valid && x_chan.ready) || (y_chan.valid && y_chan.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no beat moved for %0d cycles.", quiet_cycles);
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
